### rtl/core/ucjk_pkg.sv
// Shared types, constants and the ideograph range check for the CJK detector.
package ucjk_pkg;

  localparam int unsigned CP_W = 21;

  // Lead byte classes: (byte & mask) == code.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_ONE   = 2'd1;
  localparam logic [1:0] PEND_TWO   = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  // Ideograph ranges.
  localparam logic [CP_W-1:0] URO_LO  = 21'h004E00;
  localparam logic [CP_W-1:0] URO_HI  = 21'h009FFF;
  localparam logic [CP_W-1:0] EXTA_LO = 21'h003400;
  localparam logic [CP_W-1:0] EXTA_HI = 21'h004DBF;
  localparam logic [CP_W-1:0] CMP_LO  = 21'h00F900;
  localparam logic [CP_W-1:0] CMP_HI  = 21'h00FAFF;
  localparam logic [CP_W-1:0] SUP_LO  = 21'h020000;
  localparam logic [CP_W-1:0] SUP_HI  = 21'h02FA1F;

  typedef struct packed {
    logic [1:0]      pending;
    logic [CP_W-1:0] accum;
    logic            found;
  } dec_state_t;

  function automatic logic is_ideograph(input logic [CP_W-1:0] cp);
    is_ideograph = (cp >= URO_LO  && cp <= URO_HI)  ||
                   (cp >= EXTA_LO && cp <= EXTA_HI) ||
                   (cp >= CMP_LO  && cp <= CMP_HI)  ||
                   (cp >= SUP_LO  && cp <= SUP_HI);
  endfunction

endpackage

### rtl/core/ucjk_step.sv
// One decode step: fold a byte into the UTF-8 decoder state and update the sticky flag.
module ucjk_step (
  input  ucjk_pkg::dec_state_t cur_i,
  input  logic [7:0]           byte_i,
  output ucjk_pkg::dec_state_t nxt_o
);
  import ucjk_pkg::*;

  logic [CP_W-1:0] acc_sh;
  logic [CP_W-1:0] cp;
  logic            done;

  assign acc_sh = {cur_i.accum[CP_W-7:0], byte_i[5:0]};

  always_comb begin
    nxt_o = cur_i;
    cp    = '0;
    done  = 1'b0;
    if (cur_i.pending != PEND_NONE) begin
      // continuation: take the low six bits, top bits unchecked
      nxt_o.pending = cur_i.pending - 2'd1;
      if (cur_i.pending == PEND_ONE) begin
        done        = 1'b1;
        cp          = acc_sh;
        nxt_o.accum = '0;
      end else begin
        nxt_o.accum = acc_sh;
      end
    end else if (!byte_i[7]) begin
      done = 1'b1;
      cp   = {{(CP_W-8){1'b0}}, byte_i};
    end else if ((byte_i & LEAD2_MASK) == LEAD2_CODE) begin
      nxt_o.accum   = {{(CP_W-5){1'b0}}, byte_i[4:0]};
      nxt_o.pending = PEND_ONE;
    end else if ((byte_i & LEAD3_MASK) == LEAD3_CODE) begin
      nxt_o.accum   = {{(CP_W-4){1'b0}}, byte_i[3:0]};
      nxt_o.pending = PEND_TWO;
    end else if ((byte_i & LEAD4_MASK) == LEAD4_CODE) begin
      nxt_o.accum   = {{(CP_W-3){1'b0}}, byte_i[2:0]};
      nxt_o.pending = PEND_THREE;
    end
    // stray continuation or invalid lead byte is ignored: no change
    if (done && is_ideograph(cp)) begin
      nxt_o.found = 1'b1;
    end
  end

endmodule

### rtl/core/utf8_cjk_ideograph_detector_core.sv
// Top level of the UTF-8 CJK ideograph detector: input register, decode step, result register.
// Path: a string's last byte waits in the input register until the result register is free,
//   then loads the result register, which raises out_tvalid.
// Throughput: one byte per cycle; the input register drains every cycle unless a last byte
//   waits for the result register to free up.
// Reset: rst_n synchronous active low; clears the input and result valid bits and the
//   decoder state (pending count, accumulator, sticky flag).
module utf8_cjk_ideograph_detector_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] has_ideograph, [7:1] zero
);
  import ucjk_pkg::*;

  // Input register stage.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Decoder state.
  dec_state_t st_r;
  dec_state_t st_step;
  dec_state_t st_nxt;

  // Result register.
  logic out_vld_r;
  logic out_flag_r;

  logic out_free;
  logic consume;

  // The result slot frees up when empty or when its beat leaves this cycle.
  assign out_free  = !out_vld_r || out_tready;
  // Drain the input register; a last byte needs room in the result register.
  assign consume   = in_vld_r && (!in_last_r || out_free);
  assign in_tready = !in_vld_r || consume;

  ucjk_step u_step (
    .cur_i  (st_r),
    .byte_i (in_byte_r),
    .nxt_o  (st_step)
  );

  // A string's last byte clears everything for the next string; an open sequence is dropped.
  always_comb begin
    st_nxt = st_r;
    if (consume) begin
      if (in_last_r) begin
        st_nxt = '0;
      end else begin
        st_nxt = st_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      // input stage: load a new beat or drop the consumed one
      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
      end else if (consume) begin
        in_vld_r <= 1'b0;
      end
      st_r <= st_nxt;
      // result stage: load on a consumed last byte, drop when taken
      if (consume && in_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (consume && in_last_r) begin
      out_flag_r <= st_step.found;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_flag_r};

endmodule

### rtl/core/ucjk_checker.sv
// Port-level checks for the CJK ideograph detector and their bind to the top level.
module ucjk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // Nothing is offered after a reset edge.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With the result slot empty the input side never stalls.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result slot");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind utf8_cjk_ideograph_detector_core ucjk_checker u_ucjk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
